// File: hdl/drdq_pkg.sv
// drdq_pkg: shared types and constants for the disk request dispatch queue.
// Holds the request/result word types, op and result codes and sequencer states.
// No dependencies.
package drdq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_WIDTH_DEF   = 8;
	localparam int FIELD_W         = 8;

	typedef enum logic [1:0] {
		OP_SUBMIT   = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_PROMOTE  = 2'd2,
		OP_COMPLETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ISSUE    = 3'd0,
		KIND_DONE     = 3'd1,
		KIND_OK       = 3'd2,
		KIND_BUSY     = 3'd3,
		KIND_NOTFOUND = 3'd4,
		KIND_FULL     = 3'd5,
		KIND_NOCUR    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISS_RD,
		ST_ISS,
		ST_RESP,
		ST_SRCH,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] tag;
		logic               urgent;
		logic [FIELD_W-1:0] err_code;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] out_tag;
		logic               io_error;
		logic [FIELD_W-1:0] out_code;
		logic               last;
	} rsp_t;

endpackage

// File: hdl/disk_request_dispatch_queue.sv
// disk_request_dispatch_queue: top level, sequencer and pointer logic of the queue.
// Depends on drdq_pkg and drdq_ram (circular waiting list storage).
//
// Usage:
// Request channel (req_valid/req_ready/req) takes one word: submit, cancel,
// promote or device completion. Result channel (rsp_valid/rsp_ready/rsp) gives
// one or two words per request; the final one has last set, and an issue word,
// when there is one, comes first. The waiting list is a circular buffer in one
// RAM with a head pointer and a count; only one request is worked on at a time
// and req_ready is low until its final word is loaded into the output register.
// Submit and completion pass through ST_ISS_RD and ST_ISS first when a tag is
// issued, then ST_RESP. Cancel and promote walk the list through the single
// RAM read port, one entry per cycle: ST_SRCH finds the hit or runs past the
// last entry, ST_SHIFT closes the gap behind a hit, and ST_RESP gives the answer.
// A stalled result channel holds the output register and the sequencer waits
// on it; nothing is dropped.
// Reset empties the list, clears the in-flight slot and needs no clearing pass.
module disk_request_dispatch_queue #(
	parameter int QUEUE_DEPTH = drdq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = drdq_pkg::TAG_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  drdq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output drdq_pkg::rsp_t rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = (TAG_WIDTH < drdq_pkg::FIELD_W) ? TAG_WIDTH : drdq_pkg::FIELD_W;

	drdq_pkg::state_t state_q, state_d;
	logic [AW-1:0]  head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic           inflt_q, inflt_d;
	logic [TW-1:0]  cur_q, cur_d;
	logic [TW-1:0]  tag_q, tag_d;
	drdq_pkg::op_t  op_q, op_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic           pv_s1, pv_d;
	logic [CW-1:0]  idx_s1, idxs1_d;
	drdq_pkg::rsp_t resp_q, resp_d;
	logic           outv_q, outv_d;
	drdq_pkg::rsp_t out_q, out_d;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [TW-1:0] wdata, rdata;
	logic          out_free;
	logic [CW-1:0] idx_inc;
	logic [AW-1:0] head_dec;
	logic [TW-1:0] req_tag;

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, h} + (AW+1)'(off);
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	drdq_ram #(
		.WIDTH(TW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (we),
		.wr_addr(waddr),
		.wr_data(wdata),
		.rd_en  (re),
		.rd_addr(raddr),
		.rd_data(rdata)
	);

	assign req_ready = (state_q == drdq_pkg::ST_IDLE);
	assign rsp_valid = outv_q;
	assign rsp       = out_q;
	assign out_free  = !outv_q || rsp_ready;
	assign idx_inc   = idx_q + CW'(1);
	assign head_dec  = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);
	assign req_tag   = req.tag[TW-1:0];

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		inflt_d = inflt_q;
		cur_d   = cur_q;
		tag_d   = tag_q;
		op_d    = op_q;
		idx_d   = idx_q;
		pv_d    = pv_s1;
		idxs1_d = idx_s1;
		resp_d  = resp_q;
		outv_d  = outv_q && !rsp_ready;
		out_d   = out_q;
		we      = 1'b0;
		waddr   = head_q;
		wdata   = tag_q;
		re      = 1'b0;
		raddr   = head_q;

		case (state_q)
			drdq_pkg::ST_IDLE: begin
				if (req_valid) begin
					tag_d  = req_tag;
					op_d   = req.op;
					idx_d  = '0;
					pv_d   = 1'b0;
					resp_d = '{kind: drdq_pkg::KIND_OK,
						out_tag: drdq_pkg::FIELD_W'(req_tag),
						io_error: 1'b0, out_code: '0, last: 1'b1};
					state_d = drdq_pkg::ST_RESP;
					case (req.op)
						drdq_pkg::OP_SUBMIT: begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								resp_d.kind = drdq_pkg::KIND_FULL;
							end else begin
								we    = 1'b1;
								wdata = req_tag;
								if (req.urgent) begin
									waddr  = head_dec;
									head_d = head_dec;
								end else begin
									waddr = ptr_add(head_q, count_q);
								end
								count_d = count_q + CW'(1);
								if (!inflt_q) begin
									state_d = drdq_pkg::ST_ISS_RD;
								end
							end
						end
						drdq_pkg::OP_CANCEL, drdq_pkg::OP_PROMOTE: begin
							if (inflt_q && cur_q == req_tag) begin
								resp_d.kind = drdq_pkg::KIND_BUSY;
							end else begin
								state_d = drdq_pkg::ST_SRCH;
							end
						end
						default: begin
							if (!inflt_q) begin
								resp_d.kind    = drdq_pkg::KIND_NOCUR;
								resp_d.out_tag = '0;
							end else begin
								inflt_d         = 1'b0;
								resp_d.kind     = drdq_pkg::KIND_DONE;
								resp_d.out_tag  = drdq_pkg::FIELD_W'(cur_q);
								resp_d.io_error = |req.err_code;
								resp_d.out_code = req.err_code;
								if (count_q != '0) begin
									state_d = drdq_pkg::ST_ISS_RD;
								end
							end
						end
					endcase
				end
			end
			drdq_pkg::ST_ISS_RD: begin
				re      = 1'b1;
				raddr   = head_q;
				state_d = drdq_pkg::ST_ISS;
			end
			drdq_pkg::ST_ISS: begin
				if (out_free) begin
					outv_d  = 1'b1;
					out_d   = '{kind: drdq_pkg::KIND_ISSUE,
						out_tag: drdq_pkg::FIELD_W'(rdata),
						io_error: 1'b0, out_code: '0, last: 1'b0};
					cur_d   = rdata;
					inflt_d = 1'b1;
					head_d  = ptr_add(head_q, CW'(1));
					count_d = count_q - CW'(1);
					state_d = drdq_pkg::ST_RESP;
				end
			end
			drdq_pkg::ST_RESP: begin
				if (out_free) begin
					outv_d  = 1'b1;
					out_d   = resp_q;
					state_d = drdq_pkg::ST_IDLE;
				end
			end
			drdq_pkg::ST_SRCH: begin
				if (pv_s1 && rdata == tag_q) begin
					idx_d   = idx_s1;
					pv_d    = 1'b0;
					state_d = drdq_pkg::ST_SHIFT;
				end else if (!pv_s1 && idx_q >= count_q) begin
					resp_d.kind = drdq_pkg::KIND_NOTFOUND;
					state_d     = drdq_pkg::ST_RESP;
				end else begin
					pv_d    = idx_q < count_q;
					idxs1_d = idx_q;
					if (idx_q < count_q) begin
						re    = 1'b1;
						raddr = ptr_add(head_q, idx_q);
						idx_d = idx_inc;
					end
				end
			end
			drdq_pkg::ST_SHIFT: begin
				// close the gap: entry i+1 moves to i
				if (pv_s1) begin
					we    = 1'b1;
					waddr = ptr_add(head_q, idx_s1);
					wdata = rdata;
				end
				if (!pv_s1 && idx_inc >= count_q) begin
					state_d = drdq_pkg::ST_RESP;
					if (op_q == drdq_pkg::OP_PROMOTE) begin
						we     = 1'b1;
						waddr  = head_dec;
						wdata  = tag_q;
						head_d = head_dec;
					end else begin
						count_d = count_q - CW'(1);
					end
				end else begin
					pv_d    = idx_inc < count_q;
					idxs1_d = idx_q;
					if (idx_inc < count_q) begin
						re    = 1'b1;
						raddr = ptr_add(head_q, idx_inc);
						idx_d = idx_inc;
					end
				end
			end
			default: begin
				state_d = drdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drdq_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			inflt_q <= 1'b0;
			cur_q   <= '0;
			pv_s1   <= 1'b0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			inflt_q <= inflt_d;
			cur_q   <= cur_d;
			pv_s1   <= pv_d;
			outv_q  <= outv_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q  <= tag_d;
		op_q   <= op_d;
		idx_q  <= idx_d;
		idx_s1 <= idxs1_d;
		resp_q <= resp_d;
		out_q  <= out_d;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("waiting count above depth");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != drdq_pkg::ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_issue_sets_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drdq_pkg::ST_ISS && out_free) |=> inflt_q)
		else $error("issue word without in-flight slot");

	a_issue_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && out_q.kind == drdq_pkg::KIND_ISSUE) |-> !out_q.last)
		else $error("issue word marked last");

	a_search_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drdq_pkg::ST_SRCH) |=> $stable(count_q))
		else $error("count changed during search");

endmodule

// File: hdl/drdq_ram.sv
// drdq_ram: generic single-write, single-read RAM with registered read data.
// Depends on drdq_pkg for default sizes.
module drdq_ram #(
	parameter int WIDTH = drdq_pkg::TAG_WIDTH_DEF,
	parameter int DEPTH = drdq_pkg::QUEUE_DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: tb/disk_request_dispatch_queue_tb.sv
// Self-checking testbench for disk_request_dispatch_queue: directed and random
// request words against a scoreboard class that models the waiting list.
// Depends on drdq_pkg and the disk_request_dispatch_queue RTL.
`timescale 1ns / 100ps

module disk_request_dispatch_queue_tb;

	localparam int DEPTH       = drdq_pkg::QUEUE_DEPTH_DEF;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 142;
	localparam int LONG_HOLD   = 300;

	class dispatch_scoreboard;
		logic [7:0]     waiting[$];
		bit             dev_busy;
		logic [7:0]     cur_tag;
		drdq_pkg::rsp_t expected[$];
		int             mismatches;
		int             checked;
		int             n_req[4];
		int             n_rsp[8];

		function new();
			dev_busy   = 1'b0;
			cur_tag    = '0;
			mismatches = 0;
			checked    = 0;
			foreach (n_req[i]) n_req[i] = 0;
			foreach (n_rsp[i]) n_rsp[i] = 0;
		endfunction

		function void push_rsp(drdq_pkg::kind_t k, logic [7:0] t, logic e, logic [7:0] c,
			logic l);
			drdq_pkg::rsp_t w;
			w.kind     = k;
			w.out_tag  = t;
			w.io_error = e;
			w.out_code = c;
			w.last     = l;
			expected.push_back(w);
		endfunction

		function void issue_head();
			if (!dev_busy && waiting.size() != 0) begin
				cur_tag  = waiting.pop_front();
				dev_busy = 1'b1;
				push_rsp(drdq_pkg::KIND_ISSUE, cur_tag, 1'b0, 8'h00, 1'b0);
			end
		endfunction

		function void note_request(drdq_pkg::req_t r);
			int         pos;
			logic [7:0] done_tag;
			pos = -1;
			n_req[r.op]++;
			case (r.op)
				drdq_pkg::OP_SUBMIT: begin
					if (waiting.size() >= DEPTH) begin
						push_rsp(drdq_pkg::KIND_FULL, r.tag, 1'b0, 8'h00, 1'b1);
					end else begin
						if (r.urgent) waiting.push_front(r.tag);
						else waiting.push_back(r.tag);
						issue_head();
						push_rsp(drdq_pkg::KIND_OK, r.tag, 1'b0, 8'h00, 1'b1);
					end
				end
				drdq_pkg::OP_CANCEL, drdq_pkg::OP_PROMOTE: begin
					if (dev_busy && cur_tag == r.tag) begin
						push_rsp(drdq_pkg::KIND_BUSY, r.tag, 1'b0, 8'h00, 1'b1);
					end else begin
						for (int i = 0; i < waiting.size(); i++) begin
							if (pos < 0 && waiting[i] == r.tag) pos = i;
						end
						if (pos < 0) begin
							push_rsp(drdq_pkg::KIND_NOTFOUND, r.tag, 1'b0, 8'h00, 1'b1);
						end else begin
							waiting.delete(pos);
							if (r.op == drdq_pkg::OP_PROMOTE) waiting.push_front(r.tag);
							push_rsp(drdq_pkg::KIND_OK, r.tag, 1'b0, 8'h00, 1'b1);
						end
					end
				end
				default: begin
					if (!dev_busy) begin
						push_rsp(drdq_pkg::KIND_NOCUR, 8'h00, 1'b0, 8'h00, 1'b1);
					end else begin
						done_tag = cur_tag;
						dev_busy = 1'b0;
						issue_head();
						push_rsp(drdq_pkg::KIND_DONE, done_tag, r.err_code != 8'h00,
							r.err_code, 1'b1);
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(drdq_pkg::rsp_t got);
			drdq_pkg::rsp_t want;
			checked++;
			n_rsp[got.kind]++;
			if (expected.size() == 0) begin
				report($sformatf("unexpected word kind=%0d tag=%02h", got.kind, got.out_tag));
			end else begin
				want = expected.pop_front();
				if (got.kind !== want.kind || got.out_tag !== want.out_tag ||
				    got.io_error !== want.io_error || got.out_code !== want.out_code ||
				    got.last !== want.last)
					report($sformatf("got %0d/%02h/%0b/%02h/%0b want %0d/%02h/%0b/%02h/%0b",
						got.kind, got.out_tag, got.io_error, got.out_code, got.last,
						want.kind, want.out_tag, want.io_error, want.out_code, want.last));
			end
		endtask

		task drain_check();
			if (expected.size() != 0)
				report($sformatf("%0d expected words never arrived", expected.size()));
		endtask
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	drdq_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	drdq_pkg::rsp_t rsp;

	int send_idle  = 0;
	int rsp_stall  = 0;
	bit long_hold  = 1'b0;
	dispatch_scoreboard sb = new();

	disk_request_dispatch_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
	end

	task send_word(drdq_pkg::req_t w);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(w);
	endtask

	task send_op(drdq_pkg::op_t op, logic [7:0] tag, logic urgent, logic [7:0] code);
		drdq_pkg::req_t w;
		w.op       = op;
		w.tag      = tag;
		w.urgent   = urgent;
		w.err_code = code;
		send_word(w);
	endtask

	task wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	function logic [7:0] pick_tag();
		int r;
		r = $urandom_range(99);
		if (r < 50 && sb.waiting.size() != 0)
			return sb.waiting[$urandom_range(sb.waiting.size() - 1)];
		if (r < 65 && sb.dev_busy)
			return sb.cur_tag;
		return 8'($urandom_range(255));
	endfunction

	function drdq_pkg::req_t random_word(bit fill);
		drdq_pkg::req_t w;
		int             r;
		r          = $urandom_range(99);
		w.urgent   = 1'($urandom_range(1));
		w.err_code = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
		if (r < (fill ? 70 : 35)) begin
			w.op  = drdq_pkg::OP_SUBMIT;
			w.tag = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
		end else if (r < (fill ? 75 : 50)) begin
			w.op  = drdq_pkg::OP_CANCEL;
			w.tag = pick_tag();
		end else if (r < (fill ? 85 : 65)) begin
			w.op  = drdq_pkg::OP_PROMOTE;
			w.tag = pick_tag();
		end else begin
			w.op  = drdq_pkg::OP_COMPLETE;
			w.tag = 8'($urandom_range(255));
		end
		return w;
	endfunction

	initial begin
		#5_000_000;
		$display("FAIL disk_request_dispatch_queue");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-device corners, duplicates, busy and not-found answers
		send_op(drdq_pkg::OP_COMPLETE, 8'h00, 1'b1, 8'h5A);
		send_op(drdq_pkg::OP_CANCEL,   8'h00, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_PROMOTE,  8'hFF, 1'b1, 8'hFF);
		send_op(drdq_pkg::OP_SUBMIT,   8'h00, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_SUBMIT,   8'hFF, 1'b1, 8'hFF);
		send_op(drdq_pkg::OP_SUBMIT,   8'h33, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_SUBMIT,   8'h33, 1'b1, 8'h00);
		send_op(drdq_pkg::OP_CANCEL,   8'h00, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_PROMOTE,  8'h00, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_PROMOTE,  8'h33, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_CANCEL,   8'h33, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_PROMOTE,  8'h33, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_COMPLETE, 8'h00, 1'b0, 8'h00);
		send_op(drdq_pkg::OP_COMPLETE, 8'h00, 1'b0, 8'hFF);
		send_op(drdq_pkg::OP_COMPLETE, 8'h00, 1'b0, 8'h80);
		send_op(drdq_pkg::OP_COMPLETE, 8'h00, 1'b0, 8'h01);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  rsp_stall = 0;  end
				1: begin send_idle = 75; rsp_stall = 0;  end
				2: begin send_idle = 0;  rsp_stall = 75; end
				default: begin send_idle = 38; rsp_stall = 38; end
			endcase
			if (p == 4) long_hold = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word(p >= 4));
			wait_drained();
		end

		repeat (40) @(posedge clk);
		sb.drain_check();
		$display("Requests: %0d submit, %0d cancel, %0d promote, %0d completion",
			sb.n_req[drdq_pkg::OP_SUBMIT], sb.n_req[drdq_pkg::OP_CANCEL],
			sb.n_req[drdq_pkg::OP_PROMOTE], sb.n_req[drdq_pkg::OP_COMPLETE]);
		$display("Results (%0d): issue %0d done %0d ok %0d busy %0d notfound %0d full %0d nocur %0d",
			sb.checked, sb.n_rsp[drdq_pkg::KIND_ISSUE], sb.n_rsp[drdq_pkg::KIND_DONE],
			sb.n_rsp[drdq_pkg::KIND_OK], sb.n_rsp[drdq_pkg::KIND_BUSY],
			sb.n_rsp[drdq_pkg::KIND_NOTFOUND], sb.n_rsp[drdq_pkg::KIND_FULL],
			sb.n_rsp[drdq_pkg::KIND_NOCUR]);
		if (sb.mismatches == 0)
			$display("PASS disk_request_dispatch_queue");
		else
			$display("FAIL disk_request_dispatch_queue");
		$finish;
	end

endmodule
